// ----- hw/rtl/mfsk_pkg.sv -----
// ----------------------------------------------------------------------------
// MFSK demodulator package
// Shared widths, register indexes, sequencer states and the elaboration-time
// cosine functions used to build the coefficient ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package mfsk_pkg;

  // Field and datapath widths.
  localparam int SAMPLE_BITS   = 16;
  localparam int PHASE_BITS    = 24;
  localparam int ACC_BITS      = 40;
  localparam int COEF_BITS     = 19;
  localparam int ENERGY_BITS   = 48;
  localparam int SYM_BITS      = 8;
  localparam int TONES_BITS    = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REQUESTED_TONES = 2'd0,
    REG_BASE_STEP       = 2'd1,
    REG_SPACING_STEP    = 2'd2
  } cfg_reg_t;

  // Register reset values.
  localparam logic [TONES_BITS-1:0] RST_REQUESTED_TONES = 9'd16;
  localparam logic [PHASE_BITS-1:0] RST_BASE_STEP       = 24'd349525;
  localparam logic [PHASE_BITS-1:0] RST_SPACING_STEP    = 24'd21845;

  // Supported tone counts.
  localparam int TONES_256 = 256;
  localparam int TONES_16  = 16;
  localparam int TONES_4   = 4;
  localparam int TONES_2   = 2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_DRAIN,
    ST_E_RD,
    ST_E_LD,
    ST_E_MUL,
    ST_E_ACC,
    ST_E_FIN,
    ST_E_CMP,
    ST_OUT
  } state_t;

  // Steps of the energy multiply sequence.
  typedef enum logic [2:0] {
    MS_P_LO,
    MS_P_HI,
    MS_A1_LO,
    MS_A1_HI,
    MS_A2_LO,
    MS_A2_HI,
    MS_C_LO,
    MS_C_HI
  } mul_step_t;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

  // Q30 cosine of j/2^bits turn for the first quadrant, Taylor series by Horner.
  function automatic logic [63:0] quarter_cos(input logic [63:0] j, input int bits);
    logic [63:0] r;
    logic [63:0] r2;
    logic [63:0] t;
    logic [63:0] u;
    r  = (j * TWO_PI_Q30) >> bits;
    r2 = (r * r) >> 30;
    t  = ONE_Q30 - r2 / 64'd90;
    t  = ONE_Q30 - ((r2 * t) >> 30) / 64'd56;
    t  = ONE_Q30 - ((r2 * t) >> 30) / 64'd30;
    t  = ONE_Q30 - ((r2 * t) >> 30) / 64'd12;
    u  = ((r2 * t) >> 30) / 64'd2;
    return (u >= ONE_Q30) ? 64'd0 : ONE_Q30 - u;
  endfunction

  // Signed Q16 value of 2cos(2*pi*i/2^bits), folded from the first quadrant.
  function automatic logic signed [COEF_BITS-1:0] coef_of_index(input logic [63:0] i,
                                                                input int bits);
    logic [63:0] q;
    logic [63:0] quad;
    logic [63:0] j;
    logic [63:0] c;
    logic [63:0] m;
    q    = 64'd1 << (bits - 2);
    quad = (i >> (bits - 2)) & 64'd3;
    j    = i & (q - 64'd1);
    c    = quad[0] ? quarter_cos(q - j, bits) : quarter_cos(j, bits);
    m    = (c + 64'd4096) >> 13;
    if (quad == 64'd1 || quad == 64'd2) begin
      return -COEF_BITS'(m);
    end
    return COEF_BITS'(m);
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mfsk_ifs.sv -----
// ----------------------------------------------------------------------------
// MFSK demodulator channels
// Valid/ready interfaces for the sample input, the symbol output and the
// configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface mfsk_in_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [mfsk_pkg::SAMPLE_BITS-1:0]   sample;
  logic                                      last_of_symbol;
  modport source(output valid, output sample, output last_of_symbol, input ready);
  modport sink(input valid, input sample, input last_of_symbol, output ready);
endinterface

interface mfsk_out_if;
  logic                                valid;
  logic                                ready;
  logic [mfsk_pkg::SYM_BITS-1:0]       symbol_value;
  logic [mfsk_pkg::SYM_BITS-1:0]       tone_index;
  logic [mfsk_pkg::ENERGY_BITS-1:0]    best_energy;
  logic [mfsk_pkg::ENERGY_BITS-1:0]    second_energy;
  modport source(output valid, output symbol_value, output tone_index,
                 output best_energy, output second_energy, input ready);
  modport sink(input valid, input symbol_value, input tone_index,
               input best_energy, input second_energy, output ready);
endinterface

interface mfsk_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [mfsk_pkg::CFG_IDX_BITS-1:0]    index;
  logic [mfsk_pkg::CFG_DATA_BITS-1:0]   data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mfsk_goertzel_demodulator.sv -----
// ----------------------------------------------------------------------------
// MFSK Goertzel demodulator
// Per-tone Goertzel filters held in one filter memory, with symbol decision.
// ----------------------------------------------------------------------------
// For each accepted sample, over the active tones (2, 4, 16 or 256),
// one filter update per cycle streams through the filter memory, which is
// read and written back once per tone; then the update pipeline drains and
// the idle state takes the next sample. A sample marked as the last of its
// symbol then also runs the energy pass, which reuses one 40 x 20 bit
// multiplier eight times per tone, and may wait for the output register to
// be taken. The result goes to an output register, so the next sample is
// accepted while a symbol waits to be taken. Filters are cleared at once by
// per-entry valid bits after each symbol and after every write to a known
// configuration register.
`default_nettype none

module mfsk_goertzel_demodulator #(
  parameter int MAX_TONES      = 256,
  parameter int COS_TABLE_BITS = 10
) (
  input  wire        clk,
  input  wire        rst_n,
  mfsk_in_if.sink    in_ch,
  mfsk_out_if.source out_ch,
  mfsk_cfg_if.sink   cfg_ch
);

  localparam int TONE_W    = $clog2(MAX_TONES);
  localparam int ROM_DEPTH = 1 << COS_TABLE_BITS;
  localparam int ACC_W     = mfsk_pkg::ACC_BITS;
  localparam int PROD_W    = mfsk_pkg::COEF_BITS + ACC_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int MAG_C_W   = mfsk_pkg::COEF_BITS - 1;
  localparam int MUL_B_W   = 20;
  localparam int MUL_P_W   = ACC_W + MUL_B_W;
  localparam int ACC_A_W   = 2 * ACC_W;
  localparam int ACC_C_W   = ACC_A_W + 16;
  localparam int E_W       = mfsk_pkg::ENERGY_BITS;
  localparam int SYM_W     = mfsk_pkg::SYM_BITS;

  localparam logic signed [SUM_W-1:0] ACC_MAX_W =
    {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN_W = ~ACC_MAX_W;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

  // Cosine coefficient ROM, built at elaboration.
  typedef logic signed [mfsk_pkg::COEF_BITS-1:0] rom_t [ROM_DEPTH];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      rom[i] = mfsk_pkg::coef_of_index(64'(i), COS_TABLE_BITS);
    end
    return rom;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  // Configuration registers.
  logic [mfsk_pkg::TONES_BITS-1:0] req_tones_r;
  logic [mfsk_pkg::PHASE_BITS-1:0] base_r;
  logic [mfsk_pkg::PHASE_BITS-1:0] spacing_r;
  logic                            cfg_clear;

  // Sequencer.
  mfsk_pkg::state_t state_r, state_nxt;
  logic             in_ready;
  logic             load_out;

  // Sample and tone walk.
  logic signed [mfsk_pkg::SAMPLE_BITS-1:0] x_r;
  logic                                    last_r;
  logic [TONE_W-1:0]                       k_r;
  logic [TONE_W-1:0]                       last_k;
  logic [mfsk_pkg::PHASE_BITS-1:0]         phase_r;
  logic [mfsk_pkg::TONES_BITS-1:0]         t_lim;
  logic [mfsk_pkg::TONES_BITS-1:0]         n_tones;

  // Filter memory: {prev, prev2} per tone, with valid bits.
  logic [2*ACC_W-1:0]   fmem [MAX_TONES];
  logic [2*ACC_W-1:0]   mem_q_r;
  logic [MAX_TONES-1:0] vld_r;
  logic                 mem_we;
  logic [TONE_W-1:0]    mem_wa;
  logic [2*ACC_W-1:0]   mem_wd;
  logic signed [mfsk_pkg::COEF_BITS-1:0] coef_q_r;

  // Update pipeline.
  logic                      vb_b_r, vb_c_r;
  logic [TONE_W-1:0]         kb_r, kc_r;
  logic signed [ACC_W-1:0]   s1_q, s2_q;
  logic signed [PROD_W-1:0]  prod_c_r;
  logic signed [ACC_W-1:0]   s1_c_r, s2_c_r;
  logic signed [SUM_W-1:0]   rnd, s_sum;
  logic signed [ACC_W-1:0]   s_new;

  // Energy unit.
  logic [ACC_W-1:0]          m1_r, m2_r;
  logic [MAG_C_W-1:0]        mc_r;
  logic                      add_r;
  mfsk_pkg::mul_step_t       st_r, pst_r;
  logic                      pv_r;
  logic [ACC_W-1:0]          mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic [MUL_P_W-1:0]        prod_r;
  logic [ACC_A_W-1:0]        acc_p_r, acc_a_r;
  logic [ACC_C_W-1:0]        acc_c_r;
  logic [ACC_C_W:0]          a_ext, c_ext, e_sum;
  logic [E_W-1:0]            e_val, e_r;

  // Decision and output.
  logic [E_W-1:0]    best_r, second_r;
  logic [TONE_W-1:0] best_k_r;
  logic [SYM_W-1:0]  tone8;
  logic [SYM_W-1:0]  sym8;
  logic              out_valid_r;
  logic [SYM_W-1:0]  out_sym_r, out_tone_r;
  logic [E_W-1:0]    out_best_r, out_second_r;

  // Configuration writes; every known register clears the filters.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_tones_r <= mfsk_pkg::RST_REQUESTED_TONES;
      base_r      <= mfsk_pkg::RST_BASE_STEP;
      spacing_r   <= mfsk_pkg::RST_SPACING_STEP;
    end else if (cfg_ch.valid) begin
      case (mfsk_pkg::cfg_reg_t'(cfg_ch.index))
        mfsk_pkg::REG_REQUESTED_TONES: req_tones_r <= cfg_ch.data[mfsk_pkg::TONES_BITS-1:0];
        mfsk_pkg::REG_BASE_STEP:       base_r      <= cfg_ch.data;
        mfsk_pkg::REG_SPACING_STEP:    spacing_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (mfsk_pkg::cfg_reg_t'(cfg_ch.index))
      mfsk_pkg::REG_REQUESTED_TONES,
      mfsk_pkg::REG_BASE_STEP,
      mfsk_pkg::REG_SPACING_STEP: cfg_clear = cfg_ch.valid;
      default:                    cfg_clear = 1'b0;
    endcase
  end

  // Active tone count, limited to the memory depth and rounded down to 2, 4, 16 or 256 (at least 2).
  always_comb begin
    t_lim = (req_tones_r > mfsk_pkg::TONES_BITS'(MAX_TONES)) ?
            mfsk_pkg::TONES_BITS'(MAX_TONES) : req_tones_r;
    if (t_lim >= mfsk_pkg::TONES_BITS'(mfsk_pkg::TONES_256)) begin
      n_tones = mfsk_pkg::TONES_BITS'(mfsk_pkg::TONES_256);
    end else if (t_lim >= mfsk_pkg::TONES_BITS'(mfsk_pkg::TONES_16)) begin
      n_tones = mfsk_pkg::TONES_BITS'(mfsk_pkg::TONES_16);
    end else if (t_lim >= mfsk_pkg::TONES_BITS'(mfsk_pkg::TONES_4)) begin
      n_tones = mfsk_pkg::TONES_BITS'(mfsk_pkg::TONES_4);
    end else begin
      n_tones = mfsk_pkg::TONES_BITS'(mfsk_pkg::TONES_2);
    end
  end

  assign last_k = TONE_W'(n_tones - 1'b1);

  // Sequencer next state and strobes.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      mfsk_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_ch.valid) state_nxt = mfsk_pkg::ST_UPD;
      end
      mfsk_pkg::ST_UPD: begin
        if (k_r == last_k) state_nxt = mfsk_pkg::ST_DRAIN;
      end
      mfsk_pkg::ST_DRAIN: begin
        if (!vb_b_r && !vb_c_r) begin
          state_nxt = last_r ? mfsk_pkg::ST_E_RD : mfsk_pkg::ST_IDLE;
        end
      end
      mfsk_pkg::ST_E_RD:  state_nxt = mfsk_pkg::ST_E_LD;
      mfsk_pkg::ST_E_LD:  state_nxt = mfsk_pkg::ST_E_MUL;
      mfsk_pkg::ST_E_MUL: begin
        if (st_r == mfsk_pkg::MS_C_HI) state_nxt = mfsk_pkg::ST_E_ACC;
      end
      mfsk_pkg::ST_E_ACC: state_nxt = mfsk_pkg::ST_E_FIN;
      mfsk_pkg::ST_E_FIN: state_nxt = mfsk_pkg::ST_E_CMP;
      mfsk_pkg::ST_E_CMP: begin
        state_nxt = (k_r == last_k) ? mfsk_pkg::ST_OUT : mfsk_pkg::ST_E_RD;
      end
      mfsk_pkg::ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = mfsk_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mfsk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfsk_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ch.ready = in_ready;

  // Sample capture and the tone counter with its phase accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r    <= '0;
      last_r <= 1'b0;
    end else begin
      case (state_r)
        mfsk_pkg::ST_IDLE: begin
          if (in_ch.valid) begin
            x_r     <= in_ch.sample;
            last_r  <= in_ch.last_of_symbol;
            k_r     <= '0;
            phase_r <= base_r;
          end
        end
        mfsk_pkg::ST_UPD: begin
          if (k_r != last_k) begin
            k_r     <= k_r + 1'b1;
            phase_r <= phase_r + spacing_r;
          end
        end
        mfsk_pkg::ST_DRAIN: begin
          k_r     <= '0;
          phase_r <= base_r;
        end
        mfsk_pkg::ST_E_CMP: begin
          k_r     <= k_r + 1'b1;
          phase_r <= phase_r + spacing_r;
        end
        default: ;
      endcase
    end
  end

  // Filter memory and coefficient ROM, both read every cycle at the current tone.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fmem[mem_wa] <= mem_wd;
    end
    mem_q_r  <= fmem[k_r];
    coef_q_r <= COS_ROM[phase_r[mfsk_pkg::PHASE_BITS-1 -: COS_TABLE_BITS]];
  end

  // Valid bits: an entry that is not valid reads as a cleared filter.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear || load_out) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_wa] <= 1'b1;
    end
  end

  always_comb begin
    s1_q = vld_r[kb_r] ? mem_q_r[2*ACC_W-1:ACC_W] : '0;
    s2_q = vld_r[kb_r] ? mem_q_r[ACC_W-1:0]       : '0;
  end

  // Update pipeline: the coefficient product, then the new filter value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_b_r <= 1'b0;
      vb_c_r <= 1'b0;
    end else begin
      vb_b_r <= (state_r == mfsk_pkg::ST_UPD);
      vb_c_r <= vb_b_r;
    end
    kb_r     <= k_r;
    kc_r     <= kb_r;
    prod_c_r <= coef_q_r * s1_q;
    s1_c_r   <= s1_q;
    s2_c_r   <= s2_q;
  end

  always_comb begin
    rnd   = (SUM_W'(prod_c_r) + ROUND_HALF) >>> 16;
    s_sum = SUM_W'(x_r) + rnd - SUM_W'(s2_c_r);
    if (s_sum > ACC_MAX_W) begin
      s_new = ACC_MAX_W[ACC_W-1:0];
    end else if (s_sum < ACC_MIN_W) begin
      s_new = ACC_MIN_W[ACC_W-1:0];
    end else begin
      s_new = s_sum[ACC_W-1:0];
    end
  end

  assign mem_we = vb_c_r;
  assign mem_wa = kc_r;
  assign mem_wd = {s_new, s1_c_r};

  // Energy operand selection for the shared multiplier.
  always_comb begin
    case (st_r)
      mfsk_pkg::MS_P_LO:  begin mul_a = m1_r; mul_b = m2_r[MUL_B_W-1:0];         end
      mfsk_pkg::MS_P_HI:  begin mul_a = m1_r; mul_b = m2_r[ACC_W-1:MUL_B_W];     end
      mfsk_pkg::MS_A1_LO: begin mul_a = m1_r; mul_b = m1_r[MUL_B_W-1:0];         end
      mfsk_pkg::MS_A1_HI: begin mul_a = m1_r; mul_b = m1_r[ACC_W-1:MUL_B_W];     end
      mfsk_pkg::MS_A2_LO: begin mul_a = m2_r; mul_b = m2_r[MUL_B_W-1:0];         end
      mfsk_pkg::MS_A2_HI: begin mul_a = m2_r; mul_b = m2_r[ACC_W-1:MUL_B_W];     end
      mfsk_pkg::MS_C_LO:  begin mul_a = acc_p_r[ACC_W-1:0]; mul_b = MUL_B_W'(mc_r); end
      mfsk_pkg::MS_C_HI:  begin
        mul_a = acc_p_r[ACC_A_W-1:ACC_W];
        mul_b = MUL_B_W'(mc_r);
      end
      default:            begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Energy unit: load magnitudes, multiply step by step, accumulate each registered product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      st_r <= mfsk_pkg::MS_P_LO;
    end else begin
      pv_r <= (state_r == mfsk_pkg::ST_E_MUL);
      if (state_r == mfsk_pkg::ST_E_LD) begin
        st_r <= mfsk_pkg::MS_P_LO;
      end else if (state_r == mfsk_pkg::ST_E_MUL) begin
        st_r <= mfsk_pkg::mul_step_t'(st_r + 1'b1);
      end
    end
    if (state_r == mfsk_pkg::ST_E_LD) begin
      m1_r  <= s1_q[ACC_W-1] ? ACC_W'(-s1_q) : ACC_W'(s1_q);
      m2_r  <= s2_q[ACC_W-1] ? ACC_W'(-s2_q) : ACC_W'(s2_q);
      mc_r  <= coef_q_r[mfsk_pkg::COEF_BITS-1] ? MAG_C_W'(-coef_q_r) : MAG_C_W'(coef_q_r);
      add_r <= s1_q[ACC_W-1] ^ s2_q[ACC_W-1] ^ coef_q_r[mfsk_pkg::COEF_BITS-1];
    end
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    pst_r  <= st_r;
    if (pv_r) begin
      case (pst_r)
        mfsk_pkg::MS_P_LO:  acc_p_r <= ACC_A_W'(prod_r);
        mfsk_pkg::MS_P_HI:  acc_p_r <= acc_p_r + (ACC_A_W'(prod_r) << MUL_B_W);
        mfsk_pkg::MS_A1_LO: acc_a_r <= ACC_A_W'(prod_r);
        mfsk_pkg::MS_A1_HI: acc_a_r <= acc_a_r + (ACC_A_W'(prod_r) << MUL_B_W);
        mfsk_pkg::MS_A2_LO: acc_a_r <= acc_a_r + ACC_A_W'(prod_r);
        mfsk_pkg::MS_A2_HI: acc_a_r <= acc_a_r + (ACC_A_W'(prod_r) << MUL_B_W);
        mfsk_pkg::MS_C_LO:  acc_c_r <= ACC_C_W'(prod_r);
        mfsk_pkg::MS_C_HI:  acc_c_r <= acc_c_r + (ACC_C_W'(prod_r) << ACC_W);
        default: ;
      endcase
    end
    if (state_r == mfsk_pkg::ST_E_FIN) begin
      e_r <= e_val;
    end
  end

  // Energy combine: 2^16 (s1^2 + s2^2) minus coef*s1*s2, scaled, floored at zero and saturated.
  always_comb begin
    a_ext = {1'b0, acc_a_r, 16'b0};
    c_ext = {1'b0, acc_c_r};
    e_sum = '0;
    if (add_r) begin
      e_sum = a_ext + c_ext;
    end else if (a_ext >= c_ext) begin
      e_sum = a_ext - c_ext;
    end
    e_val = e_sum[ACC_C_W] ? {E_W{1'b1}} : e_sum[ACC_C_W-1:E_W];
  end

  // Strongest and runner-up tracking; the lower index wins ties.
  always_ff @(posedge clk) begin
    if (state_r == mfsk_pkg::ST_E_CMP) begin
      if (k_r == '0) begin
        best_r   <= e_r;
        second_r <= '0;
        best_k_r <= '0;
      end else if (e_r > best_r) begin
        second_r <= best_r;
        best_r   <= e_r;
        best_k_r <= k_r;
      end else if (e_r > second_r) begin
        second_r <= e_r;
      end
    end
  end

  // Gray decode of the winning index.
  always_comb begin
    tone8 = SYM_W'(best_k_r);
    for (int i = 0; i < SYM_W; i++) begin
      sym8[i] = ^(tone8 >> i);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (load_out) begin
      out_sym_r    <= sym8;
      out_tone_r   <= tone8;
      out_best_r   <= best_r;
      out_second_r <= second_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.symbol_value  = out_sym_r;
  assign out_ch.tone_index    = out_tone_r;
  assign out_ch.best_energy   = out_best_r;
  assign out_ch.second_energy = out_second_r;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// MFSK Goertzel demodulator testbench
// Streams audio samples grouped into symbol windows through the demodulator
// under several tone counts and tone plans. A local Goertzel predictor works
// out each symbol decision, and the monitor compares every symbol transfer
// field by field with the oldest expected symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ROM_BITS      = 10;
  localparam int  ROM_SIZE      = 1 << ROM_BITS;
  localparam int  DRAIN_CYCLES  = 4000;
  localparam int  STALL_LIMIT   = 30000;
  localparam longint ACC_HI     = 64'sd549755813887;
  localparam longint ACC_LO     = -64'sd549755813888;
  localparam logic [mfsk_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [mfsk_pkg::SAMPLE_BITS-1:0] sample;
    logic                                    last_of_symbol;
  } audio_item_t;

  typedef struct packed {
    logic [mfsk_pkg::SYM_BITS-1:0]    symbol_value;
    logic [mfsk_pkg::SYM_BITS-1:0]    tone_index;
    logic [mfsk_pkg::ENERGY_BITS-1:0] best_energy;
    logic [mfsk_pkg::ENERGY_BITS-1:0] second_energy;
  } decision_t;

  logic clk;
  logic rst_n;

  mfsk_in_if  in_ch();
  mfsk_out_if out_ch();
  mfsk_cfg_if cfg_ch();

  mfsk_goertzel_demodulator u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: register copies, Goertzel accumulators and the cosine ROM.
  logic [mfsk_pkg::TONES_BITS-1:0] tones_reg;
  logic [mfsk_pkg::PHASE_BITS-1:0] base_reg;
  logic [mfsk_pkg::PHASE_BITS-1:0] spacing_reg;
  longint                          acc_s1[256];
  longint                          acc_s2[256];
  longint                          cos_rom[ROM_SIZE];

  audio_item_t pending_samples[$];
  decision_t   expected_symbols[$];

  int  idle_pct;
  bit  send_hold;
  bit  in_took;
  int  error_count;
  int  symbols_seen;
  int  samples_sent;
  int  stall_cycles;

  // Clock generation.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Q30 cosine of j/2^ROM_BITS turn in the first quadrant, Horner Taylor series.
  function automatic longint unsigned quadrant_cos(longint unsigned j);
    longint unsigned r, r2, t, u;
    r  = (j * 64'd6746518852) >> ROM_BITS;
    r2 = (r * r) >> 30;
    t  = 64'd1073741824 - r2 / 90;
    t  = 64'd1073741824 - ((r2 * t) >> 30) / 56;
    t  = 64'd1073741824 - ((r2 * t) >> 30) / 30;
    t  = 64'd1073741824 - ((r2 * t) >> 30) / 12;
    u  = ((r2 * t) >> 30) / 2;
    return (u >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - u;
  endfunction

  // Signed Q16 value of 2cos for one ROM entry, folded by quadrant.
  function automatic longint rom_entry(int i);
    int              q, quad, j;
    longint unsigned c;
    longint          m;
    q    = ROM_SIZE / 4;
    quad = (i / q) % 4;
    j    = i % q;
    c    = (quad % 2 == 1) ? quadrant_cos(q - j) : quadrant_cos(j);
    m    = longint'((c + 64'd4096) >> 13);
    return (quad == 1 || quad == 2) ? -m : m;
  endfunction

  function automatic int active_tones(logic [mfsk_pkg::TONES_BITS-1:0] req);
    if (req >= mfsk_pkg::TONES_256) begin
      return mfsk_pkg::TONES_256;
    end
    if (req >= mfsk_pkg::TONES_16) begin
      return mfsk_pkg::TONES_16;
    end
    if (req >= mfsk_pkg::TONES_4) begin
      return mfsk_pkg::TONES_4;
    end
    return mfsk_pkg::TONES_2;
  endfunction

  function automatic longint tone_coef(int k);
    logic [31:0] phase;
    phase = 32'(base_reg) + 32'(k) * 32'(spacing_reg);
    return cos_rom[phase[mfsk_pkg::PHASE_BITS-1:mfsk_pkg::PHASE_BITS-ROM_BITS]];
  endfunction

  // Exact Goertzel energy, scaled down by 2^48, floored at zero and saturated.
  function automatic logic [mfsk_pkg::ENERGY_BITS-1:0] goertzel_power(longint s1,
                                                                      longint s2,
                                                                      longint c);
    logic signed [129:0] a1, a2, cc, acc;
    a1  = s1;
    a2  = s2;
    cc  = c;
    acc = ((a1 * a1 + a2 * a2) <<< 16) - cc * a1 * a2;
    if (acc < 0) begin
      return '0;
    end
    acc = acc >>> 48;
    if (acc[129:mfsk_pkg::ENERGY_BITS] != 0) begin
      return '1;
    end
    return acc[mfsk_pkg::ENERGY_BITS-1:0];
  endfunction

  function automatic void clear_accumulators();
    for (int k = 0; k < 256; k++) begin
      acc_s1[k] = 0;
      acc_s2[k] = 0;
    end
  endfunction

  // Filter one sample through every active tone; decide the symbol on the last one.
  function automatic void demodulate_sample(audio_item_t item);
    int                               n, best_k;
    longint                           s, x, c;
    logic [mfsk_pkg::ENERGY_BITS-1:0] e, best, second;
    logic [mfsk_pkg::SYM_BITS-1:0]    g;
    decision_t                        d;
    n      = active_tones(tones_reg);
    x      = item.sample;
    best_k = 0;
    best   = '0;
    second = '0;
    for (int k = 0; k < n; k++) begin
      c = tone_coef(k);
      s = x + ((c * acc_s1[k] + 32768) >>> 16) - acc_s2[k];
      if (s > ACC_HI) s = ACC_HI;
      if (s < ACC_LO) s = ACC_LO;
      acc_s2[k] = acc_s1[k];
      acc_s1[k] = s;
    end
    if (!item.last_of_symbol) begin
      return;
    end
    for (int k = 0; k < n; k++) begin
      e = goertzel_power(acc_s1[k], acc_s2[k], tone_coef(k));
      if (k == 0) begin
        best = e;
      end else if (e > best) begin
        second = best;
        best   = e;
        best_k = k;
      end else if (e > second) begin
        second = e;
      end
    end
    g = best_k[mfsk_pkg::SYM_BITS-1:0];
    g = g ^ (g >> 1);
    g = g ^ (g >> 2);
    g = g ^ (g >> 4);
    d.symbol_value  = g;
    d.tone_index    = best_k[mfsk_pkg::SYM_BITS-1:0];
    d.best_energy   = best;
    d.second_energy = second;
    expected_symbols = {expected_symbols, d};
    clear_accumulators();
  endfunction

  function automatic void apply_register(logic [mfsk_pkg::CFG_IDX_BITS-1:0] idx,
                                         logic [mfsk_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      mfsk_pkg::REG_REQUESTED_TONES: tones_reg   = data[mfsk_pkg::TONES_BITS-1:0];
      mfsk_pkg::REG_BASE_STEP:       base_reg    = data;
      mfsk_pkg::REG_SPACING_STEP:    spacing_reg = data;
      default:                       return;
    endcase
    clear_accumulators();
  endfunction

  // Sample driver: after a transfer, a new sample may go out at the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid          <= 1'b0;
      in_ch.sample         <= '0;
      in_ch.last_of_symbol <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (pending_samples.size() != 0 && !send_hold &&
          $urandom_range(99) >= idle_pct) begin
        in_ch.valid          <= 1'b1;
        in_ch.sample         <= pending_samples[0].sample;
        in_ch.last_of_symbol <= pending_samples[0].last_of_symbol;
        void'(pending_samples.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Symbol sink stalls at random.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);
  end

  // Monitor: predict on sample transfers, check symbol transfers, watch for hangs.
  always @(posedge clk) begin
    decision_t exp_d;
    in_took = in_ch.valid && in_ch.ready && rst_n;
    if (rst_n) begin
      if (in_took) begin
        demodulate_sample('{in_ch.sample, in_ch.last_of_symbol});
        samples_sent++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_register(cfg_ch.index, cfg_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        symbols_seen++;
        if (expected_symbols.size() == 0) begin
          $display("%0t: unexpected symbol transfer, tone_index %0d", $time,
                   out_ch.tone_index);
          error_count++;
        end else begin
          exp_d = expected_symbols.pop_front();
          if (out_ch.symbol_value !== exp_d.symbol_value) begin
            $display("%0t: symbol_value expected %0d got %0d", $time,
                     exp_d.symbol_value, out_ch.symbol_value);
            error_count++;
          end
          if (out_ch.tone_index !== exp_d.tone_index) begin
            $display("%0t: tone_index expected %0d got %0d", $time,
                     exp_d.tone_index, out_ch.tone_index);
            error_count++;
          end
          if (out_ch.best_energy !== exp_d.best_energy) begin
            $display("%0t: best_energy expected %0d got %0d", $time,
                     exp_d.best_energy, out_ch.best_energy);
            error_count++;
          end
          if (out_ch.second_energy !== exp_d.second_energy) begin
            $display("%0t: second_energy expected %0d got %0d", $time,
                     exp_d.second_energy, out_ch.second_energy);
            error_count++;
          end
        end
      end
      if (in_took || (out_ch.valid && out_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles > STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Wait until every sample is taken and every symbol has arrived, then let
  // any sample still being filtered finish.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || in_ch.valid || expected_symbols.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mfsk_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [mfsk_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_plan(int tones, int base, int spacing);
    wait_idle();
    write_reg(mfsk_pkg::REG_REQUESTED_TONES, mfsk_pkg::CFG_DATA_BITS'(tones));
    write_reg(mfsk_pkg::REG_BASE_STEP, mfsk_pkg::CFG_DATA_BITS'(base));
    write_reg(mfsk_pkg::REG_SPACING_STEP, mfsk_pkg::CFG_DATA_BITS'(spacing));
  endtask

  // Queue symbol windows. Style 0: full-range noise, 1: small noise,
  // 2: square wave of random period and amplitude, 3: mixed.
  task automatic add_symbols(int count, int max_len, int style, bit tail_open = 0);
    int len, period, amp, sty;
    audio_item_t item;
    for (int sym = 0; sym < count + tail_open; sym++) begin
      len    = $urandom_range(max_len, 1);
      period = $urandom_range(8, 1);
      amp    = $urandom_range(32767, 1);
      sty    = (style == 3) ? $urandom_range(2) : style;
      for (int i = 0; i < len; i++) begin
        case (sty)
          0:       item.sample = mfsk_pkg::SAMPLE_BITS'($urandom);
          1:       item.sample = mfsk_pkg::SAMPLE_BITS'($urandom_range(64)) - 16'sd32;
          default: item.sample = ((i / period) % 2 == 0) ? 16'(amp) : -16'(amp);
        endcase
        item.last_of_symbol = (i == len - 1) && (sym < count);
        pending_samples = {pending_samples, item};
      end
    end
  endtask

  task automatic add_sample(int value, bit last);
    audio_item_t item;
    item.sample         = mfsk_pkg::SAMPLE_BITS'(value);
    item.last_of_symbol = last;
    pending_samples = {pending_samples, item};
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last_of_symbol = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = mfsk_pkg::REG_REQUESTED_TONES;
    cfg_ch.data  = '0;
    in_took      = 1'b0;
    send_hold    = 1'b0;
    idle_pct     = 25;
    error_count  = 0;
    symbols_seen = 0;
    samples_sent = 0;
    stall_cycles = 0;
    for (int i = 0; i < ROM_SIZE; i++) begin
      cos_rom[i] = rom_entry(i);
    end
    tones_reg   = mfsk_pkg::RST_REQUESTED_TONES;
    base_reg    = mfsk_pkg::RST_BASE_STEP;
    spacing_reg = mfsk_pkg::RST_SPACING_STEP;
    clear_accumulators();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: sample extremes, single-sample symbols, ties on silence.
    add_sample(0, 1);
    add_sample(32767, 1);
    add_sample(-32768, 1);
    add_sample(-1, 0);
    add_sample(1, 1);
    for (int i = 0; i < 8; i++) begin
      add_sample((i % 2) ? -32768 : 32767, i == 7);
    end
    for (int i = 0; i < 6; i++) begin
      add_sample(16'h5555 ^ (i * 16'h0f0f), i == 5);
    end
    add_symbols(12, 16, 3);

    // Sender holds until the demodulator has caught up.
    wait (pending_samples.size() == 0);
    send_hold = 1'b1;
    add_symbols(5, 12, 2);
    while (in_ch.valid || expected_symbols.size() != 0) begin
      @(posedge clk);
    end
    send_hold = 1'b0;

    // Two tones right at DC: a double integrator under a long full-scale window.
    set_plan(2, 0, 0);
    for (int i = 0; i < 150; i++) begin
      add_sample(32767, i == 149);
    end
    add_symbols(4, 16, 0);

    // Coefficient of -2 with an alternating full-scale input.
    set_plan(0, 24'h800000, 24'h800000);
    for (int i = 0; i < 60; i++) begin
      add_sample((i % 2) ? -32768 : 32767, i == 59);
    end
    add_symbols(4, 10, 3);

    // Largest steps and four tones; a partial window stays open across an
    // ignored register write, then a real write clears it.
    set_plan(4, 24'hffffff, 24'hffffff);
    add_symbols(6, 12, 3, 1);
    wait_idle();
    write_reg(REG_UNUSED, mfsk_pkg::CFG_DATA_BITS'($urandom));
    add_symbols(4, 12, 3, 1);
    set_plan(1, $urandom_range(24'hffffff), $urandom_range(24'hffffff));
    add_symbols(6, 12, 3);

    // Full tone set, both exactly and through an oversized request.
    set_plan(256, 349525, 21845);
    add_symbols(6, 6, 3);
    set_plan(511, $urandom_range(24'hffffff), $urandom_range(4096));
    add_symbols(4, 5, 2);

    // Odd requests that round down, with a stretch without any stalls.
    set_plan(17, $urandom_range(24'hffffff), $urandom_range(24'hffffff));
    idle_pct = 0;
    add_symbols(8, 8, 3);
    wait_idle();
    idle_pct = 25;
    set_plan(15, $urandom_range(24'hffffff), $urandom_range(24'hffffff));
    add_symbols(8, 8, 3);
    set_plan(3, $urandom_range(24'hffffff), $urandom_range(24'hffffff));
    add_symbols(8, 8, 1);
    set_plan(255, $urandom_range(24'hffffff), 24'h010000);
    add_symbols(10, 8, 3);

    wait_idle();
    $display("Covered %0d samples and %0d symbols over 2, 4, 16 and 256 tones,",
             samples_sent, symbols_seen);
    $display("including DC and Nyquist tones, extreme steps and ignored writes.");
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hw/rtl/mfsk_pkg.sv
hw/rtl/mfsk_ifs.sv
hw/rtl/mfsk_goertzel_demodulator.sv
tb/tb_top.sv
